// ===== hdl/scwpi_pkg.sv =====
// Shared types, widths and constants of the steered wheel-speed PI controller.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package scwpi_pkg;

  // Fixed point fraction bits of gains, position error and accumulators
  localparam int FRAC_BITS = 8;
  localparam int FMASK     = (2 ** FRAC_BITS) - 1;

  // Field widths
  localparam int GAIN_W     = 16;
  localparam int PE_W       = 16;
  localparam int SPD_W      = 15;
  localparam int LIM_W      = 12;
  localparam int IDX_W      = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DRV_W      = 15;
  localparam int GD_OUT_W   = 21;
  localparam int ERR_W      = 16;

  // Shared multiplier: 17 x 17 signed, accumulated in 36 bits
  localparam int OPB_W  = 17;
  localparam int PROD_W = 34;
  localparam int MACC_W = 36;

  // Internal widths
  localparam int GB_W   = LIM_W + 2 * FRAC_BITS + 1;
  localparam int PDC_W  = ((MACC_W > GB_W) ? MACC_W : GB_W) + 1;
  localparam int G_W    = LIM_W + FRAC_BITS + 1;
  localparam int T_W    = SPD_W + FRAC_BITS + 2;
  localparam int TGT_W  = T_W - FRAC_BITS;
  localparam int EDIF_W = TGT_W + 1;
  localparam int INC_W  = 13 + FRAC_BITS;
  localparam int WACC_W = 15 + FRAC_BITS;
  localparam int GO_X_W = ((G_W > GD_OUT_W) ? G_W : GD_OUT_W) + 1;

  // Limits
  localparam int INC_LIMIT  = 3000;
  localparam int DIFF_LIMIT = 3000;
  localparam int AVG_LIMIT  = 9900;
  localparam int GYRO_RESET = 1000;
  localparam int INC_BOUND  = INC_LIMIT * (2 ** FRAC_BITS);
  localparam int DIFF_BOUND = DIFF_LIMIT * (2 ** FRAC_BITS);
  localparam int AVG_BOUND  = AVG_LIMIT * (2 ** FRAC_BITS);
  localparam int ERR_MAX    = (2 ** (ERR_W - 1)) - 1;
  localparam int ERR_MIN    = -(2 ** (ERR_W - 1));
  localparam int GD_MAX     = (2 ** (GD_OUT_W - 1)) - 1;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SPEED_KP       = 3'd0,
    REG_SPEED_KI       = 3'd1,
    REG_DIR_KP         = 3'd2,
    REG_DIR_KD         = 3'd3,
    REG_GYRO_LIMIT     = 3'd4,
    REG_SPEED_SETPOINT = 3'd5,
    REG_AVERAGE_MODE   = 3'd6
  } reg_idx_e;

  // Register file contents
  typedef struct packed {
    logic        [GAIN_W-1:0] speed_kp;
    logic        [GAIN_W-1:0] speed_ki;
    logic        [GAIN_W-1:0] dir_kp;
    logic        [GAIN_W-1:0] dir_kd;
    logic        [LIM_W-1:0]  gyro_limit;
    logic signed [SPD_W-1:0]  speed_setpoint;
    logic                     average_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    speed_kp:       '0,
    speed_ki:       '0,
    dir_kp:         '0,
    dir_kd:         '0,
    gyro_limit:     LIM_W'(GYRO_RESET),
    speed_setpoint: '0,
    average_mode:   1'b0
  };

  // Multiply-accumulate controls
  typedef struct packed {
    logic load;  // acc <= product
    logic add;   // acc <= acc + product
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/scwpi_if.sv =====
// Handshake channel interfaces: input word, result word and register write.
// Depends on scwpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface scwpi_in_if import scwpi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PE_W-1:0]  position_error;
  logic signed [SPD_W-1:0] left_speed;
  logic signed [SPD_W-1:0] right_speed;
  logic signed [SPD_W-1:0] average_speed;

  modport source (output valid, position_error, left_speed, right_speed, average_speed,
                  input ready);
  modport sink (input valid, position_error, left_speed, right_speed, average_speed,
                output ready);
endinterface

interface scwpi_out_if import scwpi_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [DRV_W-1:0]    left_drive;
  logic signed [DRV_W-1:0]    right_drive;
  logic signed [GD_OUT_W-1:0] gyro_demand;

  modport source (output valid, left_drive, right_drive, gyro_demand, input ready);
  modport sink (input valid, left_drive, right_drive, gyro_demand, output ready);
endinterface

interface scwpi_cfg_if import scwpi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [IDX_W-1:0]      index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/steering_cascaded_wheel_speed_pi.sv =====
// Top level of the steered wheel-speed PI controller.
// Depends on scwpi_pkg, scwpi_if, scwpi_cfg, scwpi_mac and scwpi_core.
//
//   channel  dir  modport  word
//   -------  ---  -------  ------------------------------------------------------
//   cfg_i    in   sink     index, data: register write
//   in_i     in   sink     position_error, left_speed, right_speed, average_speed
//   out_o    out  source   left_drive, right_drive, gyro_demand
//
// A new word is accepted only in idle, once the last one is through, in both
// differential and average mode: every product goes through the one shared
// multiplier, two for the steering term and two for each PI loop, with clamps
// in between. The result sits in an output register; a stalled output holds the
// sequencer only at its last step. Reset loads the register defaults and clears
// loop history and drives.
`timescale 1ns / 1ps
`default_nettype none

module steering_cascaded_wheel_speed_pi import scwpi_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  scwpi_cfg_if.sink   cfg_i,
  scwpi_in_if.sink    in_i,
  scwpi_out_if.source out_o
);

  cfg_t                     regs;
  mac_ctrl_t                mac_ctrl;
  logic [GAIN_W-1:0]        mac_gain;
  logic signed [OPB_W-1:0]  mac_opnd;
  logic signed [MACC_W-1:0] mac_acc;

  // Register file
  scwpi_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  // Shared multiply-accumulate
  scwpi_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .gain_i (mac_gain),
    .opnd_i (mac_opnd),
    .acc_o  (mac_acc)
  );

  // Sequencer and loop state
  scwpi_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .regs_i     (regs),
    .in_i       (in_i),
    .out_o      (out_o),
    .mac_ctrl_o (mac_ctrl),
    .mac_gain_o (mac_gain),
    .mac_opnd_o (mac_opnd),
    .mac_acc_i  (mac_acc)
  );

endmodule

`default_nettype wire

// ===== hdl/scwpi_cfg.sv =====
// Configuration register file, written through the register write channel.
// Depends on scwpi_pkg and scwpi_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module scwpi_cfg import scwpi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  scwpi_cfg_if.sink   cfg_i,
  output cfg_t        regs_o
);

  cfg_t regs_q, regs_d;

  // Writes are always taken
  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  // Register decode; unknown indexes are dropped
  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_SPEED_KP:       regs_d.speed_kp       = cfg_i.data[GAIN_W-1:0];
        REG_SPEED_KI:       regs_d.speed_ki       = cfg_i.data[GAIN_W-1:0];
        REG_DIR_KP:         regs_d.dir_kp         = cfg_i.data[GAIN_W-1:0];
        REG_DIR_KD:         regs_d.dir_kd         = cfg_i.data[GAIN_W-1:0];
        REG_GYRO_LIMIT:     regs_d.gyro_limit     = cfg_i.data[LIM_W-1:0];
        REG_SPEED_SETPOINT: regs_d.speed_setpoint = $signed(cfg_i.data[SPD_W-1:0]);
        REG_AVERAGE_MODE:   regs_d.average_mode   = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= CFG_RESET;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/scwpi_mac.sv =====
// Shared multiply-accumulate unit: registered 17x17 product, 36-bit accumulator.
// Depends on scwpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scwpi_mac import scwpi_pkg::*; (
  input  logic                     clk_i,
  input  mac_ctrl_t                ctrl_i,
  input  logic [GAIN_W-1:0]        gain_i,
  input  logic signed [OPB_W-1:0]  opnd_i,
  output logic signed [MACC_W-1:0] acc_o
);

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [MACC_W-1:0] acc_d, acc_q;

  // Unsigned gain times signed operand
  assign prod_d = $signed({1'b0, gain_i}) * opnd_i;

  // Accumulate one product behind the multiplier
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.load) begin
      acc_d = MACC_W'(prod_q);
    end else if (ctrl_i.add) begin
      acc_d = acc_q + MACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ===== hdl/scwpi_core.sv =====
// Sequencer and datapath: steering PD, target, per-wheel or average PI, clamps, result register.
// Depends on scwpi_pkg, scwpi_if; drives the shared scwpi_mac.
`timescale 1ns / 1ps
`default_nettype none

module scwpi_core import scwpi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     regs_i,
  scwpi_in_if.sink                 in_i,
  scwpi_out_if.source              out_o,
  output mac_ctrl_t                mac_ctrl_o,
  output logic [GAIN_W-1:0]        mac_gain_o,
  output logic signed [OPB_W-1:0]  mac_opnd_o,
  input  logic signed [MACC_W-1:0] mac_acc_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_PD_P, S_PD_D, S_PD_SUM, S_GYRO,
    S_TSUM, S_TTRN, S_ERR, S_PI_I, S_PI_P, S_PI_SUM,
    S_INC, S_ACC, S_DONE
  } state_e;

  state_e                     state_q, state_d;
  logic                       wheel_q, wheel_d;      // 0 left, 1 right
  logic signed [PE_W-1:0]     pe_q, pe_d, prev_pe_q, prev_pe_d;
  logic signed [SPD_W-1:0]    ls_q, ls_d, rs_q, rs_d, as_q, as_d;
  logic signed [OPB_W-1:0]    diff_q, diff_d;
  logic signed [G_W-1:0]      g_q, g_d;
  logic signed [T_W-1:0]      t_q, t_d;
  logic signed [TGT_W-1:0]    tgt_q, tgt_d;
  logic signed [ERR_W-1:0]    e_q, e_d;
  logic signed [ERR_W-1:0]    lep_q, lep_d, rep_q, rep_d, aep_q, aep_d;
  logic signed [INC_W-1:0]    inc_q, inc_d;
  logic signed [WACC_W-1:0]   lacc_q, lacc_d, racc_q, racc_d;
  logic                       ovalid_q, ovalid_d;
  logic signed [DRV_W-1:0]    lo_q, lo_d, ro_q, ro_d;
  logic signed [GD_OUT_W-1:0] go_q, go_d;

  logic signed [PDC_W-1:0]    gb, pdx, pdc, prnd, pdr;
  logic signed [T_W-1:0]      bs, gx, trnd, tsh;
  logic signed [TGT_W-1:0]    tsel;
  logic signed [SPD_W-1:0]    ssel;
  logic signed [EDIF_W-1:0]   ediff;
  logic signed [ERR_W-1:0]    psel;
  logic signed [MACC_W-1:0]   ib;
  logic signed [WACC_W:0]     asum, alim;
  logic signed [WACC_W-1:0]   acur, anew;
  logic signed [GO_X_W-1:0]   gox;
  logic                       avg;

  // Accumulator to drive, truncated toward zero
  function automatic logic signed [DRV_W-1:0] drive_of(logic signed [WACC_W-1:0] a);
    logic signed [WACC_W-1:0] r;
    logic signed [WACC_W-1:0] s;
    r = a[WACC_W-1] ? WACC_W'(FMASK) : WACC_W'(0);
    s = (a + r) >>> FRAC_BITS;
    return DRV_W'(s);
  endfunction

  assign avg = regs_i.average_mode;

  // Handshakes and result word
  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = ovalid_q;
  assign out_o.left_drive  = lo_q;
  assign out_o.right_drive = ro_q;
  assign out_o.gyro_demand = go_q;

  // Operand selection for the shared multiplier
  always_comb begin
    mac_ctrl_o = '0;
    mac_gain_o = '0;
    mac_opnd_o = '0;
    case (state_q)
      S_PD_P: begin
        mac_gain_o = regs_i.dir_kp;
        mac_opnd_o = OPB_W'(pe_q);
      end
      S_PD_D: begin
        mac_gain_o      = regs_i.dir_kd;
        mac_opnd_o      = diff_q;
        mac_ctrl_o.load = 1'b1;
      end
      S_PI_I: begin
        mac_gain_o = regs_i.speed_ki;
        mac_opnd_o = OPB_W'(e_q);
      end
      S_PI_P: begin
        mac_gain_o      = regs_i.speed_kp;
        mac_opnd_o      = diff_q;
        mac_ctrl_o.load = 1'b1;
      end
      S_PD_SUM, S_PI_SUM: mac_ctrl_o.add = 1'b1;
      default: ;
    endcase
  end

  // Steering clamp and truncation to Q.F
  always_comb begin
    gb   = $signed({{(PDC_W - LIM_W){1'b0}}, regs_i.gyro_limit}) <<< (2 * FRAC_BITS);
    pdx  = PDC_W'(mac_acc_i);
    if (pdx > gb) begin
      pdc = gb;
    end else if (pdx < -gb) begin
      pdc = -gb;
    end else begin
      pdc = pdx;
    end
    prnd = pdc[PDC_W-1] ? PDC_W'(FMASK) : PDC_W'(0);
    pdr  = (pdc + prnd) >>> FRAC_BITS;
  end

  // Wheel target: setpoint plus or minus steering, truncated to counts
  always_comb begin
    bs   = T_W'($signed(regs_i.speed_setpoint)) <<< FRAC_BITS;
    gx   = T_W'(g_q);
    trnd = t_q[T_W-1] ? T_W'(FMASK) : T_W'(0);
    tsh  = (t_q + trnd) >>> FRAC_BITS;
  end

  // Speed error and previous error of the active loop
  always_comb begin
    tsel  = avg ? TGT_W'($signed(regs_i.speed_setpoint)) : tgt_q;
    ssel  = avg ? as_q : (wheel_q ? rs_q : ls_q);
    ediff = EDIF_W'(tsel) - EDIF_W'(ssel);
    psel  = avg ? aep_q : (wheel_q ? rep_q : lep_q);
  end

  // Accumulator update with its clamp
  always_comb begin
    ib   = MACC_W'(INC_BOUND);
    acur = (!avg && wheel_q) ? racc_q : lacc_q;
    asum = (WACC_W + 1)'(acur) + (WACC_W + 1)'(inc_q);
    alim = avg ? (WACC_W + 1)'(AVG_BOUND) : (WACC_W + 1)'(DIFF_BOUND);
    if (asum > alim) begin
      anew = WACC_W'(alim);
    end else if (asum < -alim) begin
      anew = WACC_W'(-alim);
    end else begin
      anew = WACC_W'(asum);
    end
    gox = GO_X_W'(g_q);
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    wheel_d   = wheel_q;
    pe_d      = pe_q;
    prev_pe_d = prev_pe_q;
    ls_d      = ls_q;
    rs_d      = rs_q;
    as_d      = as_q;
    diff_d    = diff_q;
    g_d       = g_q;
    t_d       = t_q;
    tgt_d     = tgt_q;
    e_d       = e_q;
    lep_d     = lep_q;
    rep_d     = rep_q;
    aep_d     = aep_q;
    inc_d     = inc_q;
    lacc_d    = lacc_q;
    racc_d    = racc_q;
    ovalid_d  = ovalid_q;
    lo_d      = lo_q;
    ro_d      = ro_q;
    go_d      = go_q;

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          pe_d      = in_i.position_error;
          ls_d      = in_i.left_speed;
          rs_d      = in_i.right_speed;
          as_d      = in_i.average_speed;
          diff_d    = OPB_W'(in_i.position_error) - OPB_W'(prev_pe_q);
          prev_pe_d = in_i.position_error;
          state_d   = S_PD_P;
        end
      end
      S_PD_P:   state_d = S_PD_D;
      S_PD_D:   state_d = S_PD_SUM;
      S_PD_SUM: state_d = S_GYRO;
      S_GYRO: begin
        g_d     = G_W'(pdr);
        wheel_d = 1'b0;
        state_d = avg ? S_ERR : S_TSUM;
      end
      S_TSUM: begin
        t_d     = wheel_q ? (bs - gx) : (bs + gx);
        state_d = S_TTRN;
      end
      S_TTRN: begin
        tgt_d   = TGT_W'(tsh);
        state_d = S_ERR;
      end
      S_ERR: begin
        if (ediff > EDIF_W'(ERR_MAX)) begin
          e_d = ERR_W'(ERR_MAX);
        end else if (ediff < EDIF_W'(ERR_MIN)) begin
          e_d = ERR_W'(ERR_MIN);
        end else begin
          e_d = ERR_W'(ediff);
        end
        state_d = S_PI_I;
      end
      S_PI_I: begin
        diff_d = OPB_W'(e_q) - OPB_W'(psel);
        if (avg) begin
          aep_d = e_q;
        end else if (wheel_q) begin
          rep_d = e_q;
        end else begin
          lep_d = e_q;
        end
        state_d = S_PI_P;
      end
      S_PI_P:   state_d = S_PI_SUM;
      S_PI_SUM: state_d = S_INC;
      S_INC: begin
        if (mac_acc_i > ib) begin
          inc_d = INC_W'(ib);
        end else if (mac_acc_i < -ib) begin
          inc_d = INC_W'(-ib);
        end else begin
          inc_d = INC_W'(mac_acc_i);
        end
        state_d = S_ACC;
      end
      S_ACC: begin
        if (avg) begin
          lacc_d  = anew;
          racc_d  = anew;
          state_d = S_DONE;
        end else if (wheel_q) begin
          racc_d  = anew;
          state_d = S_DONE;
        end else begin
          lacc_d  = anew;
          wheel_d = 1'b1;
          state_d = S_TSUM;
        end
      end
      S_DONE: begin
        // Wait for the result register to free up
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          lo_d     = drive_of(lacc_q);
          ro_d     = drive_of(racc_q);
          if (gox > GO_X_W'(GD_MAX)) begin
            go_d = GD_OUT_W'(GD_MAX);
          end else if (gox < -GO_X_W'(GD_MAX)) begin
            go_d = -GD_OUT_W'(GD_MAX);
          end else begin
            go_d = GD_OUT_W'(gox);
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wheel_q   <= 1'b0;
      pe_q      <= '0;
      prev_pe_q <= '0;
      ls_q      <= '0;
      rs_q      <= '0;
      as_q      <= '0;
      diff_q    <= '0;
      g_q       <= '0;
      t_q       <= '0;
      tgt_q     <= '0;
      e_q       <= '0;
      lep_q     <= '0;
      rep_q     <= '0;
      aep_q     <= '0;
      inc_q     <= '0;
      lacc_q    <= '0;
      racc_q    <= '0;
      ovalid_q  <= 1'b0;
      lo_q      <= '0;
      ro_q      <= '0;
      go_q      <= '0;
    end else begin
      state_q   <= state_d;
      wheel_q   <= wheel_d;
      pe_q      <= pe_d;
      prev_pe_q <= prev_pe_d;
      ls_q      <= ls_d;
      rs_q      <= rs_d;
      as_q      <= as_d;
      diff_q    <= diff_d;
      g_q       <= g_d;
      t_q       <= t_d;
      tgt_q     <= tgt_d;
      e_q       <= e_d;
      lep_q     <= lep_d;
      rep_q     <= rep_d;
      aep_q     <= aep_d;
      inc_q     <= inc_d;
      lacc_q    <= lacc_d;
      racc_q    <= racc_d;
      ovalid_q  <= ovalid_d;
      lo_q      <= lo_d;
      ro_q      <= ro_d;
      go_q      <= go_d;
    end
  end

endmodule

`default_nettype wire
